### hdl/ambe_pkg.sv
// ----------------------------------------------------------------------------
// ambe_pkg
// shared types and constants for the mode and banked-register unit
// ----------------------------------------------------------------------------
`default_nettype none
package ambe_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned KindW   = 5;
  localparam int unsigned ModeW   = 5;
  localparam int unsigned PhysN   = 31;
  localparam int unsigned PhysAw  = 5;
  localparam int unsigned SpsrN   = 5;
  localparam int unsigned SpsrAw  = 3;

  typedef enum logic [KindW-1:0] {
    K_RESET = 5'd0, K_UNDEF = 5'd1, K_SWI = 5'd2, K_PABT = 5'd3, K_DABT = 5'd4,
    K_IRQ = 5'd5, K_FIQ = 5'd6, K_WCPSR = 5'd7, K_RCPSR = 5'd8, K_WSPSR = 5'd9,
    K_RSPSR = 5'd10, K_WREG = 5'd11, K_RREG = 5'd12, K_SIRQ = 5'd13,
    K_CIRQ = 5'd14, K_SFIQ = 5'd15, K_CFIQ = 5'd16, K_SRST = 5'd17
  } kind_t;

  localparam logic [ModeW-1:0] MODE_USR = 5'h10;
  localparam logic [ModeW-1:0] MODE_FIQ = 5'h11;
  localparam logic [ModeW-1:0] MODE_IRQ = 5'h12;
  localparam logic [ModeW-1:0] MODE_SVC = 5'h13;
  localparam logic [ModeW-1:0] MODE_ABT = 5'h17;
  localparam logic [ModeW-1:0] MODE_UND = 5'h1B;
  localparam logic [ModeW-1:0] MODE_SYS = 5'h1F;

  localparam logic [SpsrAw-1:0] SPSR_NONE = 3'd5;
  localparam logic [PhysAw-1:0] PC_SLOT   = 5'd15;

  localparam logic [DataW-1:0] VEC_RESET = 32'h0000_0004;
  localparam logic [DataW-1:0] VEC_UNDEF = 32'h0000_0008;
  localparam logic [DataW-1:0] VEC_SWI   = 32'h0000_000C;
  localparam logic [DataW-1:0] VEC_PABT  = 32'h0000_0010;
  localparam logic [DataW-1:0] VEC_DABT  = 32'h0000_0014;
  localparam logic [DataW-1:0] VEC_IRQ   = 32'h0000_001C;
  localparam logic [DataW-1:0] VEC_FIQ   = 32'h0000_0020;

  function automatic logic mode_known(input logic [ModeW-1:0] m);
    return m == MODE_USR || m == MODE_FIQ || m == MODE_IRQ || m == MODE_SVC ||
           m == MODE_ABT || m == MODE_UND || m == MODE_SYS;
  endfunction

  function automatic logic [PhysAw-1:0] phys_slot(input logic [ModeW-1:0] m,
                                                  input logic [3:0] r);
    logic [PhysAw-1:0] rr;
    rr = {1'b0, r};
    if (r < 4'd8 || r == 4'd15) return rr;
    if (m == MODE_FIQ) return rr + 5'd8;
    if (r < 4'd13) return rr;
    unique case (m)
      MODE_SVC: return rr + 5'd10;
      MODE_ABT: return rr + 5'd12;
      MODE_UND: return rr + 5'd14;
      MODE_IRQ: return rr + 5'd16;
      default:  return rr;
    endcase
  endfunction

  function automatic logic [SpsrAw-1:0] spsr_slot(input logic [ModeW-1:0] m);
    unique case (m)
      MODE_FIQ: return 3'd0;
      MODE_IRQ: return 3'd1;
      MODE_SVC: return 3'd2;
      MODE_ABT: return 3'd3;
      MODE_UND: return 3'd4;
      default:  return SPSR_NONE;
    endcase
  endfunction

endpackage
`default_nettype wire

### hdl/arm_mode_bank_exception_unit.sv
// an input transfer passes the memory read state and then the write-back state, which registers the result
// a new transfer waits until the result has left, so an output stall holds off the next event
// reset: synchronous active low; a clearing pass zeroes the bank memory
// and the saved-status memory before the first input is taken
// ----------------------------------------------------------------------------
// arm_mode_bank_exception_unit
// ARMv4 banked register file, status registers and exception entry
// ----------------------------------------------------------------------------
`default_nettype none
module arm_mode_bank_exception_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [4:0]  in_tuser,   // kind
  input  wire logic [39:0] in_tdata,   // reg_index[3:0], value[35:4], zero fill
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata   // read_value[31:0], mode_now[36:32],
                                       // privileged[37], interrupt_request[38],
                                       // bad_mode[39]
);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_READ, S_WRITE} state_t;

  state_t                       state_r;
  logic [ambe_pkg::PhysAw-1:0]  clr_r;
  // banked register memory and saved-status memory, one read and one write port each
  logic [31:0] phys_mem [ambe_pkg::PhysN];
  logic [31:0] spsr_mem [ambe_pkg::SpsrN];
  logic [31:0] phys_rd_r, spsr_rd_r;

  logic [4:0]  kind_r;
  logic [3:0]  idx_r;
  logic [31:0] val_r;
  logic [31:0] pc_r;         // r15 lives here; slot 15 of the memory is not used for reads
  logic [3:0]  flags_r;
  logic [2:0]  mt_r;         // I, F, T
  logic [4:0]  mode_r;
  logic [2:0]  pend_r;       // rst, fiq, irq

  logic [ambe_pkg::PhysAw-1:0] paddr;
  logic [31:0] cpsr;
  logic        ex_go, ex_f;
  logic [4:0]  ex_mode;
  logic [31:0] ex_link, ex_vec;

  assign in_tready = (state_r == S_IDLE) && !out_tvalid;
  assign cpsr = {flags_r, 20'd0, mt_r, mode_r};
  assign paddr = ambe_pkg::phys_slot(mode_r, idx_r[3:0]);

  // exception entry decode
  always_comb begin
    ex_go = 1'b1; ex_f = 1'b0; ex_mode = ambe_pkg::MODE_SVC;
    ex_link = pc_r; ex_vec = ambe_pkg::VEC_RESET;
    unique case (kind_r)
      ambe_pkg::K_RESET: ex_f = 1'b1;
      ambe_pkg::K_UNDEF: begin
        ex_mode = ambe_pkg::MODE_UND; ex_link = pc_r - 32'd4; ex_vec = ambe_pkg::VEC_UNDEF;
      end
      ambe_pkg::K_SWI: begin
        ex_link = pc_r - 32'd4; ex_vec = ambe_pkg::VEC_SWI;
      end
      ambe_pkg::K_PABT: begin ex_mode = ambe_pkg::MODE_ABT; ex_vec = ambe_pkg::VEC_PABT; end
      ambe_pkg::K_DABT: begin ex_mode = ambe_pkg::MODE_ABT; ex_vec = ambe_pkg::VEC_DABT; end
      ambe_pkg::K_IRQ:  begin ex_mode = ambe_pkg::MODE_IRQ; ex_vec = ambe_pkg::VEC_IRQ; end
      ambe_pkg::K_FIQ:  begin
        ex_mode = ambe_pkg::MODE_FIQ; ex_vec = ambe_pkg::VEC_FIQ; ex_f = 1'b1;
      end
      default: ex_go = 1'b0;
    endcase
  end

  // memory ports: read every cycle, write in clear/write
  always_ff @(posedge clk) begin
    phys_rd_r <= phys_mem[paddr];
    spsr_rd_r <= spsr_mem[ambe_pkg::spsr_slot(mode_r)];
    if (state_r == S_CLEAR) begin
      phys_mem[clr_r] <= '0;
      if (clr_r < 5'(ambe_pkg::SpsrN)) spsr_mem[clr_r[ambe_pkg::SpsrAw-1:0]] <= '0;
    end else if (state_r == S_WRITE) begin
      if (ex_go) begin
        phys_mem[ambe_pkg::phys_slot(ex_mode, 4'd14)] <= ex_link;
        if (ambe_pkg::spsr_slot(ex_mode) != ambe_pkg::SPSR_NONE)
          spsr_mem[ambe_pkg::spsr_slot(ex_mode)] <= cpsr;
      end else if (kind_r == ambe_pkg::K_WREG) begin
        phys_mem[paddr] <= val_r;
      end else if (kind_r == ambe_pkg::K_WSPSR &&
                   ambe_pkg::spsr_slot(mode_r) != ambe_pkg::SPSR_NONE) begin
        spsr_mem[ambe_pkg::spsr_slot(mode_r)] <= val_r;
      end
    end
  end

  logic [31:0] rd_nxt;
  logic        bad_nxt;
  logic [2:0]  mt_nxt;
  logic [4:0]  mode_nxt;
  logic [2:0]  pend_nxt;
  logic [3:0]  flags_nxt;
  logic [31:0] pc_nxt;

  always_comb begin
    rd_nxt = '0; bad_nxt = 1'b0; mt_nxt = mt_r; mode_nxt = mode_r;
    pend_nxt = pend_r; flags_nxt = flags_r; pc_nxt = pc_r;
    if (ex_go) begin
      mode_nxt = ex_mode;
      pc_nxt = ex_vec;
      mt_nxt = {1'b1, mt_r[1] | ex_f, 1'b0};
      if (kind_r == ambe_pkg::K_RESET) pend_nxt = '0;
    end else begin
      unique case (kind_r)
        ambe_pkg::K_WCPSR: begin
          if (!ambe_pkg::mode_known(val_r[4:0])) bad_nxt = 1'b1;
          else begin
            flags_nxt = val_r[31:28]; mt_nxt = val_r[7:5]; mode_nxt = val_r[4:0];
          end
        end
        ambe_pkg::K_RCPSR: rd_nxt = cpsr;
        ambe_pkg::K_RSPSR: begin
          if (mode_r == ambe_pkg::MODE_USR) rd_nxt = cpsr;
          else if (ambe_pkg::spsr_slot(mode_r) != ambe_pkg::SPSR_NONE) rd_nxt = spsr_rd_r;
          else bad_nxt = 1'b1;
        end
        ambe_pkg::K_WREG: if (paddr == ambe_pkg::PC_SLOT) pc_nxt = val_r;
        // r15 comes from the pc register, exception entry only updates that copy
        ambe_pkg::K_RREG: rd_nxt = (paddr == ambe_pkg::PC_SLOT) ? pc_r : phys_rd_r;
        ambe_pkg::K_SIRQ: pend_nxt[0] = 1'b1;
        ambe_pkg::K_CIRQ: pend_nxt[0] = 1'b0;
        ambe_pkg::K_SFIQ: pend_nxt[1] = 1'b1;
        ambe_pkg::K_CFIQ: pend_nxt[1] = 1'b0;
        ambe_pkg::K_SRST: pend_nxt[2] = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR; clr_r <= '0; out_tvalid <= 1'b0;
      flags_r <= '0; mt_r <= 3'b110; mode_r <= ambe_pkg::MODE_SVC;
      pend_r <= '0; pc_r <= '0;
    end else begin
      if (out_tvalid && out_tready) out_tvalid <= 1'b0;
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 5'd1;
          if (clr_r == 5'(ambe_pkg::PhysN - 1)) state_r <= S_IDLE;
        end
        S_IDLE: if (in_tvalid && in_tready) begin
          kind_r <= in_tuser; idx_r <= in_tdata[3:0]; val_r <= in_tdata[35:4];
          state_r <= S_READ;
        end
        S_READ: state_r <= S_WRITE;   // memories are read here
        S_WRITE: begin
          flags_r <= flags_nxt; mt_r <= mt_nxt; mode_r <= mode_nxt;
          pend_r <= pend_nxt; pc_r <= pc_nxt;
          out_tvalid <= 1'b1;
          out_tdata <= {bad_nxt,
                        (!mt_nxt[1] && pend_nxt[1]) || (!mt_nxt[2] && pend_nxt[0]),
                        mode_nxt != ambe_pkg::MODE_USR, mode_nxt, rd_nxt};
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### hdl/ambe_checker.sv
// ----------------------------------------------------------------------------
// ambe_checker
// port-level checks for the mode and banked-register unit
// ----------------------------------------------------------------------------
`default_nettype none
module ambe_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [39:0] out_tdata
);
  // no new transfer while a result waits
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken with result pending");
  // privileged matches mode
  a_priv: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[37] == (out_tdata[36:32] != ambe_pkg::MODE_USR)))
    else $error("privileged mismatch");
  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
  // result is valid once the transfer has passed the read and write-back states
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> ##3 out_tvalid) else $error("result missing");
endmodule

bind arm_mode_bank_exception_unit ambe_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
);
`default_nettype wire

### sim/arm_mode_bank_exception_unit_tb.sv
// ----------------------------------------------------------------------------
// arm_mode_bank_exception_unit_tb
// drives random and directed mode, bank and exception events into the unit,
// predicts each result from a local model of the register banks and status,
// and compares every output transfer field by field
// ----------------------------------------------------------------------------
`default_nettype none
module arm_mode_bank_exception_unit_tb;

  typedef struct packed {
    logic [4:0]  kind;
    logic [3:0]  reg_index;
    logic [31:0] value;
  } event_t;

  typedef struct packed {
    logic        bad_mode;
    logic        interrupt_request;
    logic        privileged;
    logic [4:0]  mode_now;
    logic [31:0] read_value;
  } status_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [4:0]  in_tuser;   // kind
  logic [39:0] in_tdata;   // reg_index[3:0], value[35:4], zero fill
  logic        out_tvalid;
  logic        out_tready;
  logic [39:0] out_tdata;  // read_value, mode_now, privileged, irq request, bad_mode

  arm_mode_bank_exception_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // predictor copy of the unit's state
  logic [31:0] bank_regs [ambe_pkg::PhysN];
  logic [31:0] saved_psr [ambe_pkg::SpsrN];
  logic [3:0]  nzcv;
  logic [2:0]  ift;        // bit2 I, bit1 F, bit0 T
  logic [4:0]  cur_mode;
  logic [2:0]  lines;      // bit0 irq, bit1 fiq, bit2 reset

  event_t  pending_events[$];
  status_t expected_status[$];
  int      mismatches;
  bit      calm;           // no idling in the last part of the run
  int      in_gap, out_gap;
  logic    in_tready_seen; // handshake seen at the last rising edge

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Mismatches found");
    $finish;
  end

  function automatic logic [4:0] slot_of(input logic [4:0] m, input logic [3:0] r);
    if (r < 4'd8 || r == 4'd15) return {1'b0, r};
    if (m == ambe_pkg::MODE_FIQ) return 5'd16 + {1'b0, r} - 5'd8;
    if (r < 4'd13) return {1'b0, r};
    case (m)
      ambe_pkg::MODE_SVC: return 5'd23 + {1'b0, r} - 5'd13;
      ambe_pkg::MODE_ABT: return 5'd25 + {1'b0, r} - 5'd13;
      ambe_pkg::MODE_UND: return 5'd27 + {1'b0, r} - 5'd13;
      ambe_pkg::MODE_IRQ: return 5'd29 + {1'b0, r} - 5'd13;
      default:  return {1'b0, r};
    endcase
  endfunction

  function automatic int psr_of(input logic [4:0] m);
    case (m)
      ambe_pkg::MODE_FIQ: return 0;
      ambe_pkg::MODE_IRQ: return 1;
      ambe_pkg::MODE_SVC: return 2;
      ambe_pkg::MODE_ABT: return 3;
      ambe_pkg::MODE_UND: return 4;
      default:  return 5;
    endcase
  endfunction

  function automatic logic [31:0] cpsr_now();
    return {nzcv, 20'd0, ift[2], ift[1], ift[0], cur_mode};
  endfunction

  function automatic bit legal_mode(input logic [4:0] m);
    return m == ambe_pkg::MODE_USR || m == ambe_pkg::MODE_FIQ ||
           m == ambe_pkg::MODE_IRQ || m == ambe_pkg::MODE_SVC ||
           m == ambe_pkg::MODE_ABT || m == ambe_pkg::MODE_UND ||
           m == ambe_pkg::MODE_SYS;
  endfunction

  task automatic take_exception(input logic [4:0] m, input logic [31:0] link,
                                input logic [31:0] vec, input bit mask_fiq);
    int s;
    s = psr_of(m);
    if (s < 5) saved_psr[s] = cpsr_now();
    cur_mode = m;
    bank_regs[slot_of(m, 4'd14)] = link;
    bank_regs[15] = vec;
    ift = {1'b1, ift[1] | mask_fiq, 1'b0};
  endtask

  // advance the model by one event and queue the status it should report
  task automatic predict_event(input event_t ev);
    logic [31:0] pc, rd;
    logic        bad;
    int          s;
    status_t     st;
    pc = bank_regs[15];
    rd = '0;
    bad = 1'b0;
    case (ev.kind)
      ambe_pkg::K_RESET: begin
        take_exception(ambe_pkg::MODE_SVC, pc, ambe_pkg::VEC_RESET, 1'b1);
        lines = '0;
      end
      ambe_pkg::K_UNDEF:
        take_exception(ambe_pkg::MODE_UND, pc - 32'd4, ambe_pkg::VEC_UNDEF, 1'b0);
      ambe_pkg::K_SWI:
        take_exception(ambe_pkg::MODE_SVC, pc - 32'd4, ambe_pkg::VEC_SWI, 1'b0);
      ambe_pkg::K_PABT: take_exception(ambe_pkg::MODE_ABT, pc, ambe_pkg::VEC_PABT, 1'b0);
      ambe_pkg::K_DABT: take_exception(ambe_pkg::MODE_ABT, pc, ambe_pkg::VEC_DABT, 1'b0);
      ambe_pkg::K_IRQ:  take_exception(ambe_pkg::MODE_IRQ, pc, ambe_pkg::VEC_IRQ, 1'b0);
      ambe_pkg::K_FIQ:  take_exception(ambe_pkg::MODE_FIQ, pc, ambe_pkg::VEC_FIQ, 1'b1);
      ambe_pkg::K_WCPSR: begin
        if (!legal_mode(ev.value[4:0])) begin
          bad = 1'b1;
        end else begin
          nzcv = ev.value[31:28];
          ift = ev.value[7:5];
          cur_mode = ev.value[4:0];
        end
      end
      ambe_pkg::K_RCPSR: rd = cpsr_now();
      ambe_pkg::K_WSPSR: begin
        s = psr_of(cur_mode);
        if (s < 5) saved_psr[s] = ev.value;
      end
      ambe_pkg::K_RSPSR: begin
        s = psr_of(cur_mode);
        if (cur_mode == ambe_pkg::MODE_USR) rd = cpsr_now();
        else if (s < 5) rd = saved_psr[s];
        else bad = 1'b1;
      end
      ambe_pkg::K_WREG:  bank_regs[slot_of(cur_mode, ev.reg_index)] = ev.value;
      ambe_pkg::K_RREG:  rd = bank_regs[slot_of(cur_mode, ev.reg_index)];
      ambe_pkg::K_SIRQ:  lines[0] = 1'b1;
      ambe_pkg::K_CIRQ:  lines[0] = 1'b0;
      ambe_pkg::K_SFIQ:  lines[1] = 1'b1;
      ambe_pkg::K_CFIQ:  lines[1] = 1'b0;
      ambe_pkg::K_SRST:  lines[2] = 1'b1;
      default: ;
    endcase
    st.read_value = rd;
    st.mode_now = cur_mode;
    st.privileged = cur_mode != ambe_pkg::MODE_USR;
    st.interrupt_request = (!ift[1] && lines[1]) || (!ift[2] && lines[0]);
    st.bad_mode = bad;
    expected_status.push_back(st);
  endtask

  function automatic event_t mk(input logic [4:0] k, input logic [3:0] r,
                                input logic [31:0] v);
    event_t e;
    e.kind = k;
    e.reg_index = r;
    e.value = v;
    return e;
  endfunction

  function automatic logic [4:0] pick_mode();
    case ($urandom_range(0, 6))
      0: return ambe_pkg::MODE_USR;
      1: return ambe_pkg::MODE_FIQ;
      2: return ambe_pkg::MODE_IRQ;
      3: return ambe_pkg::MODE_SVC;
      4: return ambe_pkg::MODE_ABT;
      5: return ambe_pkg::MODE_UND;
      default: return ambe_pkg::MODE_SYS;
    endcase
  endfunction

  // driver: inputs change on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready_seen) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
        in_tvalid <= 1'b0;
      end else if (pending_events.size() > 0) begin
        in_tvalid <= 1'b1;
        in_tuser  <= pending_events[0].kind;
        in_tdata  <= {4'd0, pending_events[0].value, pending_events[0].reg_index};
        predict_event(pending_events.pop_front());
        if (!calm && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 13);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    if (rst_n) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 11) == 0) out_gap <= $urandom_range(1, 13);
      end
    end
  end

  always @(posedge clk) in_tready_seen <= in_tvalid && in_tready;

  // monitor: check each output transfer against the oldest expectation
  always @(posedge clk) begin
    status_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_status.size() == 0) begin
        $display("%0t: unexpected transfer, actual %h", $realtime, out_tdata);
        mismatches <= mismatches + 1;
      end else begin
        want = expected_status.pop_front();
        if (got !== want) begin
          $display({"%0t: expected rd=%h mode=%h priv=%b irq=%b bad=%b, ",
                    "actual rd=%h mode=%h priv=%b irq=%b bad=%b"},
                   $realtime, want.read_value, want.mode_now, want.privileged,
                   want.interrupt_request, want.bad_mode, got.read_value, got.mode_now,
                   got.privileged, got.interrupt_request, got.bad_mode);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  initial begin
    int i, n, k;
    logic [4:0] m;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = '0;
    in_tdata = '0;
    out_tready = 1'b0;
    mismatches = 0;
    in_gap = 0;
    out_gap = 0;
    calm = 1'b0;
    for (i = 0; i < ambe_pkg::PhysN; i++) bank_regs[i] = '0;
    for (i = 0; i < ambe_pkg::SpsrN; i++) saved_psr[i] = '0;
    nzcv = '0;
    ift = 3'b110;
    cur_mode = ambe_pkg::MODE_SVC;
    lines = '0;

    // directed: every event kind, field extremes and the special cases
    pending_events.push_back(mk(ambe_pkg::K_RSPSR, 4'd0, '0));
    pending_events.push_back(mk(ambe_pkg::K_WREG, 4'd15, 32'hFFFF_FFFF));
    pending_events.push_back(mk(ambe_pkg::K_RREG, 4'd15, '0));
    pending_events.push_back(mk(ambe_pkg::K_UNDEF, 4'd0, '0));
    pending_events.push_back(mk(ambe_pkg::K_RREG, 4'd15, '0));
    pending_events.push_back(mk(ambe_pkg::K_SWI, 4'd0, '0));
    pending_events.push_back(mk(ambe_pkg::K_PABT, 4'd0, '0));
    pending_events.push_back(mk(ambe_pkg::K_DABT, 4'd0, '0));
    pending_events.push_back(mk(ambe_pkg::K_SIRQ, 4'd0, '0));
    pending_events.push_back(mk(ambe_pkg::K_SFIQ, 4'd0, '0));
    // unknown mode is flagged, then same mode keeps banks but clears masks
    pending_events.push_back(mk(ambe_pkg::K_WCPSR, 4'd0, 32'hFFFF_FF00));
    pending_events.push_back(mk(ambe_pkg::K_WCPSR, 4'd0,
                                {4'hF, 20'd0, 3'b000, ambe_pkg::MODE_ABT}));
    pending_events.push_back(mk(ambe_pkg::K_IRQ, 4'd0, '0));
    pending_events.push_back(mk(ambe_pkg::K_FIQ, 4'd0, '0));
    pending_events.push_back(mk(ambe_pkg::K_WSPSR, 4'd0, 32'hA5A5_5A5A));
    pending_events.push_back(mk(ambe_pkg::K_RSPSR, 4'd0, '0));
    pending_events.push_back(mk(ambe_pkg::K_WREG, 4'd8, 32'h8888_0001));
    pending_events.push_back(mk(ambe_pkg::K_RCPSR, 4'd0, '0));
    // system mode: spsr read flagged, spsr write dropped
    pending_events.push_back(mk(ambe_pkg::K_WCPSR, 4'd0,
                                {4'h0, 20'd0, 3'b001, ambe_pkg::MODE_SYS}));
    pending_events.push_back(mk(ambe_pkg::K_WSPSR, 4'd0, 32'h1234_5678));
    pending_events.push_back(mk(ambe_pkg::K_RSPSR, 4'd0, '0));
    // user mode: spsr read returns the cpsr
    pending_events.push_back(mk(ambe_pkg::K_WCPSR, 4'd0,
                                {4'h5, 20'd0, 3'b000, ambe_pkg::MODE_USR}));
    pending_events.push_back(mk(ambe_pkg::K_RSPSR, 4'd0, '0));
    pending_events.push_back(mk(ambe_pkg::K_SRST, 4'd0, '0));
    pending_events.push_back(mk(ambe_pkg::K_CIRQ, 4'd0, '0));
    pending_events.push_back(mk(ambe_pkg::K_CFIQ, 4'd0, '0));
    pending_events.push_back(mk(ambe_pkg::K_RESET, 4'd0, '0));
    pending_events.push_back(mk(5'd31, 4'd15, 32'hFFFF_FFFF));

    // random: register reads and writes, mode switches, any event kind, some raw noise
    n = 0;
    while (n < 450) begin
      k = $urandom_range(0, 99);
      if (k < 10) begin
        m = pick_mode();
        pending_events.push_back(mk(ambe_pkg::K_WCPSR, 4'd0,
          {$urandom} & 32'hF000_00E0 | {27'd0, m}));
      end else if (k < 14) begin
        pending_events.push_back(mk(ambe_pkg::K_WCPSR, 4'd0, $urandom));
      end else if (k < 40) begin
        pending_events.push_back(mk(ambe_pkg::K_WREG, 4'($urandom_range(0, 15)), $urandom));
      end else if (k < 65) begin
        pending_events.push_back(mk(ambe_pkg::K_RREG, 4'($urandom_range(0, 15)), $urandom));
      end else if (k < 95) begin
        pending_events.push_back(mk(5'($urandom_range(0, 17)), 4'($urandom_range(0, 15)),
                                    $urandom));
      end else begin
        pending_events.push_back(mk(5'($urandom_range(18, 31)), 4'($urandom_range(0, 15)),
                                    $urandom));
      end
      n++;
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // last stretch runs without idling
    wait (pending_events.size() < 60);
    calm = 1'b1;
    wait (pending_events.size() == 0);
    wait (expected_status.size() == 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire
